[sv/ecvt_pkg.sv]
// ecvt_pkg: shared types and constants for the sheave setpoint controller
// no dependencies
`default_nettype none
package ecvt_pkg;

   typedef enum logic [2:0] {
      MODE_POWER       = 3'd0,
      MODE_TORQUE      = 3'd1,
      MODE_ACCEL       = 3'd2,
      MODE_BRAKE_CHECK = 3'd3,
      MODE_HOMING      = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_D,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;

   // register indexes
   localparam logic [2:0] REG_TGT_POWER  = 3'd0;
   localparam logic [2:0] REG_TGT_TORQUE = 3'd1;
   localparam logic [2:0] REG_ENGAGE     = 3'd2;
   localparam logic [2:0] REG_MAX_RPM    = 3'd3;
   localparam logic [2:0] REG_GAIN_P     = 3'd4;
   localparam logic [2:0] REG_GAIN_D     = 3'd5;
   localparam logic [2:0] REG_MAX_SP     = 3'd6;
   localparam logic [2:0] REG_MAX_SP_BC  = 3'd7;

   localparam int RPM_W  = 14;
   localparam int GAIN_W = 16;
   localparam int CSR_W  = 24;
   localparam int DIV_STEPS = 26;

   localparam int BRAKE_LIMIT   = 1000;
   localparam int SWITCH_LIMIT  = 2000;
   localparam int HOME_FAST     = 400;
   localparam int HOME_SLOW     = 50;
   localparam int CLEAR_TIME_MS = 400;
   localparam int HOME_CLEAR    = 800;
   localparam int SEL_POWER     = 800;
   localparam int SEL_TORQUE    = 1600;
   localparam int SEL_ACCEL     = 2400;
   localparam int SEL_BRAKE_CHK = 3200;
   localparam int IDLE_SETPOINT  = 0;
   localparam int FLOOR_MAX_SP   = 4000;
   localparam int HOME_SP        = 0;
   localparam int LIMIT_POSITION = 0;

endpackage
`default_nettype wire

[sv/ecvt_if.sv]
// ecvt_if: valid/ready channel interfaces for requests, results and csr writes
// no dependencies
`default_nettype none
interface ecvt_req_if #(parameter int ADC_BITS = 12, parameter int POSITION_BITS = 24);
   logic                            valid;
   logic                            ready;
   logic [13:0]                     shaft_rpm;
   logic signed [POSITION_BITS-1:0] sheave_pos;
   logic [ADC_BITS-1:0]             brake_level;
   logic [ADC_BITS-1:0]             selector_level;
   logic [ADC_BITS-1:0]             limit_level;
   logic [31:0]                     now_ms;
   modport source (output valid, shaft_rpm, sheave_pos, brake_level,
                   selector_level, limit_level, now_ms, input ready);
   modport sink (input valid, shaft_rpm, sheave_pos, brake_level,
                 selector_level, limit_level, now_ms, output ready);
endinterface

interface ecvt_rsp_if #(parameter int POSITION_BITS = 24);
   logic                            valid;
   logic                            ready;
   logic signed [POSITION_BITS-1:0] sheave_cmd;
   logic                            brake_on;
   logic                            set_home;
   logic [2:0]                      mode;
   modport source (output valid, sheave_cmd, brake_on, set_home, mode,
                   input ready);
   modport sink (input valid, sheave_cmd, brake_on, set_home, mode,
                 output ready);
endinterface

interface ecvt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/ecvt_alu.sv]
// ecvt_alu: shared signed multiplier and restoring divider step
// depends on ecvt_pkg
`default_nettype none
module ecvt_alu
   import ecvt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               mul_en,
   input  wire logic signed [16:0] mul_a,
   input  wire logic [15:0]        mul_b,
   output logic signed [33:0]      mul_q,
   input  wire logic               div_load,
   input  wire logic               div_step,
   input  wire logic [25:0]        div_num,
   input  wire logic [13:0]        div_den,
   output logic [25:0]             div_quo
);
   logic signed [33:0] mul_ff;
   logic [25:0] quo_ff, quo_in;
   logic [14:0] rem_ff, rem_in;
   logic [13:0] den_ff;
   logic [14:0] trial;

   // one multiply, registered
   always_ff @(posedge clock) begin
      if (mul_en) mul_ff <= 34'(mul_a * $signed({1'b0, mul_b}));
   end
   assign mul_q = mul_ff;

   // one quotient bit a cycle while div_step is high
   always_comb begin
      trial  = {rem_ff[13:0], quo_ff[25]};
      quo_in = {quo_ff[24:0], 1'b0};
      rem_in = trial;
      if (trial >= {1'b0, den_ff}) begin
         rem_in    = trial - {1'b0, den_ff};
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         quo_ff <= div_num;
         rem_ff <= '0;
         den_ff <= div_den;
      end else if (div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end
   assign div_quo = quo_ff;
endmodule
`default_nettype wire

[sv/ecvt_sheave_setpoint_controller.sv]
// ecvt_sheave_setpoint_controller: top level, csr bank, sequencer and datapath
// depends on ecvt_pkg, ecvt_if, ecvt_alu
//
// Usage: one request per control tick on req (engine rpm, motor position,
// brake, selector and limit ADC readings, millisecond time). Exactly one
// result follows on rsp: motor setpoint, brake flag, set_home and mode.
// Configuration registers are to be written on csr (index, data) only while
// idle; the block does not enforce this. Per request the sequencer runs the
// proportional and derivative multiplies on the shared multiplier, then 26
// steps of the shared bit-serial divider for the rpm floor and a finish step.
// A new request is taken only after its result is accepted: req.ready is
// low while a request is at work and while its result waits.
// When the receiver stalls, the result holds in the output register and no
// further request is taken. Synchronous reset restores the register defaults
// and puts the controller in homing mode with no homing progress.
`default_nettype none
module ecvt_sheave_setpoint_controller
   import ecvt_pkg::*;
#(
   parameter int ADC_BITS      = 12,
   parameter int POSITION_BITS = 24
)(
   input wire logic clock,
   input wire logic reset,
   ecvt_req_if.sink   req,
   ecvt_rsp_if.source rsp,
   ecvt_csr_if.sink   csr
);
   localparam int PW = POSITION_BITS;
   localparam int XW = PW + 24;
   localparam logic signed [XW-1:0] POS_MAX = XW'((64'sd1 <<< (PW-1)) - 1);
   localparam logic signed [XW-1:0] POS_MIN = -POS_MAX - 1;

   // csr bank
   logic [13:0] tgt_pw_ff, tgt_tq_ff, engage_ff, max_rpm_ff;
   logic [15:0] gp_ff, gd_ff;
   logic signed [23:0] max_sp_ff, max_sp_bc_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_pw_ff <= 14'd3400; tgt_tq_ff <= 14'd2800;
         engage_ff <= 14'd1800; max_rpm_ff <= 14'd3800;
         gp_ff <= 16'd256; gd_ff <= 16'd0;
         max_sp_ff <= 24'sd8000; max_sp_bc_ff <= 24'sd6000;
      end else if (csr.valid) begin
         case (csr.index)
            REG_TGT_POWER:  tgt_pw_ff <= csr.data[13:0];
            REG_TGT_TORQUE: tgt_tq_ff <= csr.data[13:0];
            REG_ENGAGE:     engage_ff <= csr.data[13:0];
            REG_MAX_RPM:    max_rpm_ff <= csr.data[13:0];
            REG_GAIN_P:     gp_ff <= csr.data[15:0];
            REG_GAIN_D:     gd_ff <= csr.data[15:0];
            REG_MAX_SP:     max_sp_ff <= csr.data;
            REG_MAX_SP_BC:  max_sp_bc_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // captured request and control state
   state_type state_ff, state_in;
   logic [4:0] cnt_ff;
   mode_type mode_ff, mode_in, prev_ff, prev_in;
   logic signed [15:0] perr_ff;
   logic trig_ff;
   logic [31:0] ttime_ff;
   logic [13:0] rpm_ff;
   logic signed [PW-1:0] pos_ff;
   logic pressed_ff, limit_ff;
   logic [31:0] now_ff;
   logic signed [16:0] err_ff;
   logic signed [34:0] acc_ff;

   logic accept;
   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // mode selection at acceptance
   always_comb begin
      mode_in = mode_ff;
      prev_in = prev_ff;
      if (mode_ff != MODE_HOMING) begin
         if (32'(req.selector_level) < 32'(SEL_POWER)) mode_in = MODE_POWER;
         else if (32'(req.selector_level) < 32'(SEL_TORQUE)) mode_in = MODE_TORQUE;
         else if (32'(req.selector_level) < 32'(SEL_ACCEL)) mode_in = MODE_ACCEL;
         else if (32'(req.selector_level) < 32'(SEL_BRAKE_CHK))
            mode_in = MODE_BRAKE_CHECK;
         else if (prev_ff != MODE_HOMING) mode_in = MODE_HOMING;
         prev_in = mode_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_D;
         ST_MUL_D:  state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (rsp.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // shared unit operands
   logic mul_en, div_load, div_step;
   logic signed [16:0] mul_a;
   logic [15:0] mul_b;
   logic signed [33:0] mul_q;
   logic [25:0] div_quo;
   logic signed [16:0] derr;
   logic [13:0] rpm_off;
   assign derr    = 17'(perr_ff) - err_ff;
   assign rpm_off = rpm_ff - engage_ff;

   always_comb begin
      mul_en   = 1'b0;
      div_load = 1'b0;
      div_step = 1'b0;
      mul_a    = -err_ff;
      mul_b    = gp_ff;
      case (state_ff)
         ST_MUL_P: begin mul_en = 1'b1; div_load = 1'b1; end
         ST_MUL_D: begin mul_en = 1'b1; mul_a = derr; mul_b = gd_ff; end
         ST_DIV:   div_step = 1'b1;
         default: ;
      endcase
   end

   ecvt_alu u_alu (
      .clock, .mul_en, .mul_a, .mul_b, .mul_q,
      .div_load, .div_step,
      .div_num(26'(rpm_off) * 26'(FLOOR_MAX_SP - IDLE_SETPOINT)),
      .div_den(max_rpm_ff - engage_ff),
      .div_quo
   );

   // finish: step, floor, clamps and homing
   logic signed [34:0] q;
   logic signed [34:0] step;
   logic signed [XW-1:0] x, floor_sp, ceil_sp, sp;
   logic below, done;
   mode_type fin_mode;
   always_comb begin
      q    = acc_ff;
      step = q[34] ? -((-q) >>> 8) : (q >>> 8);
      if (max_rpm_ff <= engage_ff) floor_sp = XW'(FLOOR_MAX_SP);
      else if (div_quo > 26'(FLOOR_MAX_SP)) floor_sp = XW'(FLOOR_MAX_SP);
      else floor_sp = XW'(IDLE_SETPOINT) + XW'($signed({1'b0, div_quo}));
      ceil_sp = (mode_ff == MODE_BRAKE_CHECK) ? XW'(max_sp_bc_ff) : XW'(max_sp_ff);
      x = XW'(pos_ff) + XW'(step);
      if (x < floor_sp) x = floor_sp;
      if (x > ceil_sp) x = ceil_sp;
      below    = rpm_ff < engage_ff;
      done     = 1'b0;
      fin_mode = mode_ff;
      if (mode_ff == MODE_HOMING) begin
         if (!trig_ff) sp = limit_ff ? XW'(pos_ff) : XW'(pos_ff) - XW'(HOME_FAST);
         else if ((now_ff - ttime_ff) < 32'(CLEAR_TIME_MS))
            sp = XW'(pos_ff) + XW'(HOME_FAST);
         else if (limit_ff) begin
            done = 1'b1;
            fin_mode = MODE_POWER;
            sp = XW'(LIMIT_POSITION + HOME_CLEAR);
         end else sp = XW'(pos_ff) - XW'(HOME_SLOW);
      end else if (pressed_ff) sp = XW'(HOME_SP);
      else if (below) sp = XW'(IDLE_SETPOINT);
      else sp = x;
      if (sp > POS_MAX) sp = POS_MAX;
      if (sp < POS_MIN) sp = POS_MIN;
   end

   // output register
   logic signed [PW-1:0] osp_ff;
   logic obrk_ff, ohome_ff;
   assign rsp.valid      = (state_ff == ST_OUT);
   assign rsp.sheave_cmd = osp_ff;
   assign rsp.brake_on   = obrk_ff;
   assign rsp.set_home   = ohome_ff;
   assign rsp.mode       = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= MODE_HOMING;
         prev_ff  <= MODE_HOMING;
         perr_ff  <= '0;
         trig_ff  <= 1'b0;
         ttime_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == ST_DIV) ? cnt_ff + 5'd1 : '0;
         if (accept) begin
            mode_ff <= mode_in;
            prev_ff <= prev_in;
            if (mode_ff != MODE_HOMING && mode_in == MODE_HOMING) begin
               trig_ff  <= 1'b0;
               ttime_ff <= '0;
            end
         end
         if (state_ff == ST_FINISH) begin
            if (mode_ff == MODE_HOMING) begin
               mode_ff <= fin_mode;
               if (!trig_ff && limit_ff) begin
                  trig_ff  <= 1'b1;
                  ttime_ff <= now_ff;
               end else if (done) begin
                  trig_ff  <= 1'b0;
                  ttime_ff <= '0;
               end
            end else if (!below) perr_ff <= err_ff[15:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         rpm_ff     <= req.shaft_rpm;
         pos_ff     <= req.sheave_pos;
         pressed_ff <= 32'(req.brake_level) > 32'(BRAKE_LIMIT);
         limit_ff   <= 32'(req.limit_level) > 32'(SWITCH_LIMIT);
         now_ff     <= req.now_ms;
         err_ff     <= $signed({3'b0, (mode_in == MODE_TORQUE) ? tgt_tq_ff : tgt_pw_ff})
                       - $signed({3'b0, req.shaft_rpm});
      end
      if (state_ff == ST_MUL_D) acc_ff <= 35'(mul_q);
      if (state_ff == ST_DIV && cnt_ff == 5'd0) acc_ff <= acc_ff + 35'(mul_q);
      if (state_ff == ST_FINISH) begin
         osp_ff   <= PW'(sp);
         obrk_ff  <= pressed_ff;
         ohome_ff <= done;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("request taken while result pending");
   a_home_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.set_home) |-> rsp.mode == MODE_POWER)
      else $error("set_home without return to power");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL_P) else $error("sequencer missed request");
`endif
endmodule
`default_nettype wire
